// ===== rtl/core/ttt_pkg.sv =====
// Shared types and codes for the tag track table.
// Used by the slot cells, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package ttt_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int ID_BITS_DEF     = 10;

   // Widths fixed by the request and response fields
   localparam int TAG_ID_W   = 10;
   localparam int POSE_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int READ_IDX_W = 4;
   localparam int REMOVED_W  = 5;
   // Slot index carried in the token; covers the largest table
   localparam int SLOT_IDX_W = 8;

   localparam logic [1:0] REQ_DETECT = 2'd0;
   localparam logic [1:0] REQ_AGE    = 2'd1;

   localparam logic [2:0] STAT_UPDATED = 3'd0;
   localparam logic [2:0] STAT_INSERTED = 3'd1;
   localparam logic [2:0] STAT_DROPPED = 3'd2;
   localparam logic [2:0] STAT_AGED    = 3'd3;
   localparam logic [2:0] STAT_READ    = 3'd4;

   localparam logic [1:0] CSR_VALIDATION_HITS = 2'd0;
   localparam logic [1:0] CSR_VALID_FORGET    = 2'd1;
   localparam logic [1:0] CSR_UNVALID_FORGET  = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0] validation_hits;
      logic [COUNT_W-1:0] validated_forget;
      logic [COUNT_W-1:0] unvalidated_forget;
   } cfg_type;

   // Request token walking the cell chain, gathering its result on the way
   typedef struct packed {
      logic                  valid;
      logic [1:0]            req;
      logic [TAG_ID_W-1:0]   id;
      logic [POSE_W-1:0]     angle;
      logic [POSE_W-1:0]     distance;
      logic [READ_IDX_W-1:0] read_index;
      logic                  matched;
      logic                  free_found;
      logic [SLOT_IDX_W-1:0] free_idx;
      logic [REMOVED_W-1:0]  removed;
      logic                  e_valid;
      logic [TAG_ID_W-1:0]   e_id;
      logic [POSE_W-1:0]     e_angle;
      logic [POSE_W-1:0]     e_distance;
      logic [COUNT_W-1:0]    e_hits;
      logic [COUNT_W-1:0]    e_missed;
      logic                  e_validated;
   } token_type;

   // Insert broadcast from the chain tail to the first free slot
   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic [TAG_ID_W-1:0]   id;
      logic [POSE_W-1:0]     angle;
      logic [POSE_W-1:0]     distance;
   } ins_type;

   typedef struct packed {
      logic [2:0]           status;
      logic                 e_valid;
      logic [TAG_ID_W-1:0]  e_id;
      logic [POSE_W-1:0]    e_angle;
      logic [POSE_W-1:0]    e_distance;
      logic [COUNT_W-1:0]   e_hits;
      logic [COUNT_W-1:0]   e_missed;
      logic                 e_validated;
      logic [REMOVED_W-1:0] removed;
   } result_type;

endpackage

// ===== rtl/core/tag_track_table.sv =====
// Tag track table: one request at a time; a new request is stalled until the response
// of the last one is loaded into the output stage. Each request walks the slot
// cell chain one cell a cycle, and an insert is issued from the chain tail.
// A finished response may wait in the output stage while the next request is taken.
// Reset (synchronous): table empty, registers 5 / 10 / 3, no response pending.
`timescale 1ns / 1ps

module tag_track_table #(
   parameter int TABLE_SLOTS = ttt_pkg::TABLE_SLOTS_DEF,
   parameter int ID_BITS     = ttt_pkg::ID_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_type,
   input  logic [ttt_pkg::TAG_ID_W-1:0]            req_tag_id,
   input  logic signed [ttt_pkg::POSE_W-1:0]       req_tag_angle,
   input  logic [ttt_pkg::POSE_W-1:0]              req_tag_distance,
   input  logic [ttt_pkg::READ_IDX_W-1:0]          req_read_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [2:0]                              rsp_status,
   output logic                                    rsp_entry_valid,
   output logic [ttt_pkg::TAG_ID_W-1:0]            rsp_entry_id,
   output logic signed [ttt_pkg::POSE_W-1:0]       rsp_entry_angle,
   output logic [ttt_pkg::POSE_W-1:0]              rsp_entry_distance,
   output logic [ttt_pkg::COUNT_W-1:0]             rsp_entry_hits,
   output logic [ttt_pkg::COUNT_W-1:0]             rsp_entry_missed,
   output logic                                    rsp_entry_validated,
   output logic [ttt_pkg::REMOVED_W-1:0]           rsp_removed_count,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [1:0]                              csr_index,
   input  logic [ttt_pkg::COUNT_W-1:0]             csr_data
);

   ttt_pkg::cfg_type    cfg_ff;
   ttt_pkg::token_type  tok_link [TABLE_SLOTS+1];
   ttt_pkg::token_type  last;
   ttt_pkg::ins_type    ins;
   ttt_pkg::result_type res, pend_ff, rsp_ff;
   logic                busy_ff, pend_valid_ff, rsp_valid_ff;
   logic                accept, rsp_free, rsp_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.validation_hits    <= 8'd5;
         cfg_ff.validated_forget   <= 8'd10;
         cfg_ff.unvalidated_forget <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ttt_pkg::CSR_VALIDATION_HITS: cfg_ff.validation_hits    <= csr_data;
            ttt_pkg::CSR_VALID_FORGET:    cfg_ff.validated_forget   <= csr_data;
            ttt_pkg::CSR_UNVALID_FORGET:  cfg_ff.unvalidated_forget <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = busy_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      tok_link[0]            = '0;
      tok_link[0].valid      = accept;
      tok_link[0].req        = req_type;
      tok_link[0].id         = req_tag_id;
      tok_link[0].angle      = req_tag_angle;
      tok_link[0].distance   = req_tag_distance;
      tok_link[0].read_index = req_read_index;
   end

   for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      ttt_cell #(
         .CELL_INDEX (g),
         .ID_BITS    (ID_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .ins     (ins),
         .tok_in  (tok_link[g]),
         .tok_out (tok_link[g+1])
      );
   end

   assign last = tok_link[TABLE_SLOTS];

   // Chain tail: settle status and place an unknown tag in the first free slot
   always_comb begin
      ins          = '0;
      ins.idx      = last.free_idx;
      ins.id       = last.id;
      ins.angle    = last.angle;
      ins.distance = last.distance;
      res          = '0;
      case (last.req)
         ttt_pkg::REQ_DETECT: begin
            if (last.matched) begin
               res.status = ttt_pkg::STAT_UPDATED;
            end else if (last.free_found) begin
               res.status = ttt_pkg::STAT_INSERTED;
               ins.en     = last.valid;
            end else begin
               res.status = ttt_pkg::STAT_DROPPED;
            end
         end
         ttt_pkg::REQ_AGE: begin
            res.status  = ttt_pkg::STAT_AGED;
            res.removed = last.removed;
         end
         default: begin
            res.status      = ttt_pkg::STAT_READ;
            res.e_valid     = last.e_valid;
            res.e_id        = last.e_id;
            res.e_angle     = last.e_angle;
            res.e_distance  = last.e_distance;
            res.e_hits      = last.e_hits;
            res.e_missed    = last.e_missed;
            res.e_validated = last.e_validated;
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = rsp_free && (pend_valid_ff || last.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (rsp_load) begin
            busy_ff <= 1'b0;
         end
         // hold a finished response while the output stage is stalled
         pend_valid_ff <= pend_valid_ff ? !rsp_free : (last.valid && !rsp_free);
         rsp_valid_ff  <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (last.valid && !rsp_free) begin
         pend_ff <= res;
      end
      if (rsp_load) begin
         rsp_ff <= pend_valid_ff ? pend_ff : res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_entry_valid     = rsp_ff.e_valid;
   assign rsp_entry_id        = rsp_ff.e_id;
   assign rsp_entry_angle     = rsp_ff.e_angle;
   assign rsp_entry_distance  = rsp_ff.e_distance;
   assign rsp_entry_hits      = rsp_ff.e_hits;
   assign rsp_entry_missed    = rsp_ff.e_missed;
   assign rsp_entry_validated = rsp_ff.e_validated;
   assign rsp_removed_count   = rsp_ff.removed;

endmodule

// ===== rtl/core/ttt_cell.sv =====
// One table slot: holds a tracked tag and processes the request token as it passes.
// Depends on ttt_pkg.
`timescale 1ns / 1ps

module ttt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int ID_BITS    = ttt_pkg::ID_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ttt_pkg::cfg_type    cfg,
   input  ttt_pkg::ins_type    ins,
   input  ttt_pkg::token_type  tok_in,
   output ttt_pkg::token_type  tok_out
);

   localparam int KEY_W = (ID_BITS > ttt_pkg::TAG_ID_W) ? ID_BITS : ttt_pkg::TAG_ID_W;
   localparam logic [ttt_pkg::SLOT_IDX_W-1:0] MY_IDX = ttt_pkg::SLOT_IDX_W'(CELL_INDEX);

   logic                          valid_ff, valid_in;
   logic                          seen_ff, seen_in;
   logic [ID_BITS-1:0]            id_ff, id_in;
   logic [ttt_pkg::POSE_W-1:0]    angle_ff, angle_in;
   logic [ttt_pkg::POSE_W-1:0]    dist_ff, dist_in;
   logic [ttt_pkg::COUNT_W-1:0]   hits_ff, hits_in;
   logic [ttt_pkg::COUNT_W-1:0]   missed_ff, missed_in;
   ttt_pkg::token_type            tok_ff, tok_in_nx;

   logic [KEY_W-1:0]              tok_key, ins_key, slot_key;
   logic                          id_match;
   logic [ttt_pkg::COUNT_W:0]     hits_inc;
   logic [ttt_pkg::COUNT_W-1:0]   hits_upd;
   logic [ttt_pkg::COUNT_W-1:0]   missed_inc;
   logic                          is_validated;
   logic [ttt_pkg::COUNT_W-1:0]   limit;

   assign tok_key  = KEY_W'(tok_in.id);
   assign ins_key  = KEY_W'(ins.id);
   assign slot_key = KEY_W'(id_ff);
   assign id_match = valid_ff && (id_ff == tok_key[ID_BITS-1:0]);

   assign hits_inc = {1'b0, hits_ff} + 9'd1;
   assign hits_upd = (hits_inc > {1'b0, cfg.validation_hits}) ? cfg.validation_hits
                                                               : hits_inc[7:0];
   assign missed_inc   = (missed_ff == 8'hFF) ? 8'hFF : missed_ff + 8'd1;
   assign is_validated = hits_ff >= cfg.validation_hits;
   assign limit        = is_validated ? cfg.validated_forget : cfg.unvalidated_forget;

   always_comb begin
      tok_in_nx = tok_in;
      valid_in  = valid_ff;
      seen_in   = seen_ff;
      id_in     = id_ff;
      angle_in  = angle_ff;
      dist_in   = dist_ff;
      hits_in   = hits_ff;
      missed_in = missed_ff;

      if (tok_in.valid) begin
         case (tok_in.req)
            ttt_pkg::REQ_DETECT: begin
               if (id_match && !tok_in.matched) begin
                  hits_in           = hits_upd;
                  angle_in          = tok_in.angle;
                  dist_in           = tok_in.distance;
                  missed_in         = '0;
                  seen_in           = 1'b1;
                  tok_in_nx.matched = 1'b1;
               end else if (!valid_ff && !tok_in.free_found) begin
                  tok_in_nx.free_found = 1'b1;
                  tok_in_nx.free_idx   = MY_IDX;
               end
            end
            ttt_pkg::REQ_AGE: begin
               if (valid_ff && !seen_ff) begin
                  missed_in = missed_inc;
                  if (missed_inc >= limit) begin
                     valid_in          = 1'b0;
                     tok_in_nx.removed = tok_in.removed + 5'd1;
                  end
               end
               seen_in = 1'b0;
            end
            default: begin
               // read; type three reads as well
               if (valid_ff && ({4'b0, tok_in.read_index} == MY_IDX)) begin
                  tok_in_nx.e_valid     = 1'b1;
                  tok_in_nx.e_id        = slot_key[ttt_pkg::TAG_ID_W-1:0];
                  tok_in_nx.e_angle     = angle_ff;
                  tok_in_nx.e_distance  = dist_ff;
                  tok_in_nx.e_hits      = hits_ff;
                  tok_in_nx.e_missed    = missed_ff;
                  tok_in_nx.e_validated = is_validated;
               end
            end
         endcase
      end

      // insert lands only when no token is in the chain
      if (ins.en && (ins.idx == MY_IDX)) begin
         valid_in  = 1'b1;
         seen_in   = 1'b1;
         id_in     = ins_key[ID_BITS-1:0];
         angle_in  = ins.angle;
         dist_in   = ins.distance;
         hits_in   = 8'd1;
         missed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      angle_ff  <= angle_in;
      dist_ff   <= dist_in;
      hits_ff   <= hits_in;
      missed_ff <= missed_in;
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/ttt_checker.sv =====
// Port-level checks for the tag track table, bound to the top level.
// Depends on ttt_pkg and the tag_track_table ports.
`timescale 1ns / 1ps

module ttt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [2:0]                         rsp_status,
   input logic                               rsp_entry_valid,
   input logic [ttt_pkg::COUNT_W-1:0]        rsp_entry_hits,
   input logic                               rsp_entry_validated,
   input logic [ttt_pkg::REMOVED_W-1:0]      rsp_removed_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                && $stable(rsp_removed_count))
      else $error("stalled response changed");

   a_entry_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ttt_pkg::STAT_READ |->
         !rsp_entry_valid && !rsp_entry_validated && rsp_entry_hits == '0)
      else $error("entry data outside a read response");

   a_removed_only_on_age: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ttt_pkg::STAT_AGED |-> rsp_removed_count == '0)
      else $error("removed count outside an end of frame response");

   a_validated_needs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_validated |-> rsp_entry_valid)
      else $error("validated flag on an empty slot");

endmodule

bind tag_track_table ttt_checker u_ttt_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_entry_valid     (rsp_entry_valid),
   .rsp_entry_hits      (rsp_entry_hits),
   .rsp_entry_validated (rsp_entry_validated),
   .rsp_removed_count   (rsp_removed_count)
);

// ===== dv/tag_track_checker.sv =====
// Port checker for the tag track table: predicts every response from the accepted
// requests and register writes, then compares accepted responses in order.
// Depends on ttt_pkg for field widths, request and status codes and the result type.
`timescale 1ns / 1ps

module tag_track_checker #(
   parameter int TABLE_SLOTS = ttt_pkg::TABLE_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [ttt_pkg::TAG_ID_W-1:0]        req_tag_id,
   input  logic signed [ttt_pkg::POSE_W-1:0]   req_tag_angle,
   input  logic [ttt_pkg::POSE_W-1:0]          req_tag_distance,
   input  logic [ttt_pkg::READ_IDX_W-1:0]      req_read_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [2:0]                          rsp_status,
   input  logic                                rsp_entry_valid,
   input  logic [ttt_pkg::TAG_ID_W-1:0]        rsp_entry_id,
   input  logic signed [ttt_pkg::POSE_W-1:0]   rsp_entry_angle,
   input  logic [ttt_pkg::POSE_W-1:0]          rsp_entry_distance,
   input  logic [ttt_pkg::COUNT_W-1:0]         rsp_entry_hits,
   input  logic [ttt_pkg::COUNT_W-1:0]         rsp_entry_missed,
   input  logic                                rsp_entry_validated,
   input  logic [ttt_pkg::REMOVED_W-1:0]       rsp_removed_count,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [ttt_pkg::COUNT_W-1:0]         csr_data,
   output int                                  fail_count,
   output int                                  pending
);

   import ttt_pkg::*;

   logic [COUNT_W-1:0]  hits_limit;
   logic [COUNT_W-1:0]  vld_forget;
   logic [COUNT_W-1:0]  unvld_forget;

   logic                trk_valid  [TABLE_SLOTS];
   logic [TAG_ID_W-1:0] trk_id     [TABLE_SLOTS];
   logic [POSE_W-1:0]   trk_angle  [TABLE_SLOTS];
   logic [POSE_W-1:0]   trk_dist   [TABLE_SLOTS];
   logic [COUNT_W-1:0]  trk_hits   [TABLE_SLOTS];
   logic [COUNT_W-1:0]  trk_missed [TABLE_SLOTS];
   logic                trk_seen   [TABLE_SLOTS];

   result_type          track_rsp_q [$];

   // Apply one request to the shadow table and return the response it causes
   function automatic result_type track_step(logic [1:0] kind, logic [TAG_ID_W-1:0] id,
         logic [POSE_W-1:0] ang, logic [POSE_W-1:0] rng, logic [READ_IDX_W-1:0] idx);
      result_type         r;
      int                 s;
      int                 hit;
      int                 free;
      int                 removed;
      logic [COUNT_W:0]   bumped;
      logic [COUNT_W-1:0] lim;
      r = '0;
      case (kind)
         REQ_DETECT: begin
            hit  = -1;
            free = -1;
            for (s = 0; s < TABLE_SLOTS; s++) begin
               if (hit < 0 && trk_valid[s] && trk_id[s] == id) hit = s;
               if (free < 0 && !trk_valid[s]) free = s;
            end
            if (hit >= 0) begin
               // a count above a lowered threshold falls back to it
               bumped = {1'b0, trk_hits[hit]} + 1'b1;
               if (bumped > {1'b0, hits_limit}) bumped = {1'b0, hits_limit};
               trk_hits[hit]   = bumped[COUNT_W-1:0];
               trk_angle[hit]  = ang;
               trk_dist[hit]   = rng;
               trk_missed[hit] = '0;
               trk_seen[hit]   = 1'b1;
               r.status = STAT_UPDATED;
            end else if (free >= 0) begin
               trk_valid[free]  = 1'b1;
               trk_id[free]     = id;
               trk_angle[free]  = ang;
               trk_dist[free]   = rng;
               trk_hits[free]   = 8'd1;
               trk_missed[free] = '0;
               trk_seen[free]   = 1'b1;
               r.status = STAT_INSERTED;
            end else begin
               r.status = STAT_DROPPED;
            end
         end
         REQ_AGE: begin
            removed = 0;
            for (s = 0; s < TABLE_SLOTS; s++) begin
               if (trk_valid[s] && !trk_seen[s]) begin
                  if (trk_missed[s] != 8'hFF) trk_missed[s] = trk_missed[s] + 1'b1;
                  lim = (trk_hits[s] >= hits_limit) ? vld_forget : unvld_forget;
                  if (trk_missed[s] >= lim) begin
                     trk_valid[s] = 1'b0;
                     removed++;
                  end
               end
               trk_seen[s] = 1'b0;
            end
            r.status  = STAT_AGED;
            r.removed = removed[REMOVED_W-1:0];
         end
         default: begin
            // type three reads like type two
            r.status = STAT_READ;
            if (int'(idx) < TABLE_SLOTS && trk_valid[idx]) begin
               r.e_valid     = 1'b1;
               r.e_id        = trk_id[idx];
               r.e_angle     = trk_angle[idx];
               r.e_distance  = trk_dist[idx];
               r.e_hits      = trk_hits[idx];
               r.e_missed    = trk_missed[idx];
               r.e_validated = (trk_hits[idx] >= hits_limit);
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         hits_limit   = 8'd5;
         vld_forget   = 8'd10;
         unvld_forget = 8'd3;
         for (int s = 0; s < TABLE_SLOTS; s++) begin
            trk_valid[s]  = 1'b0;
            trk_id[s]     = '0;
            trk_angle[s]  = '0;
            trk_dist[s]   = '0;
            trk_hits[s]   = '0;
            trk_missed[s] = '0;
            trk_seen[s]   = 1'b0;
         end
         track_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VALIDATION_HITS: hits_limit   = csr_data;
               CSR_VALID_FORGET:    vld_forget   = csr_data;
               CSR_UNVALID_FORGET:  unvld_forget = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.status      = rsp_status;
            got.e_valid     = rsp_entry_valid;
            got.e_id        = rsp_entry_id;
            got.e_angle     = rsp_entry_angle;
            got.e_distance  = rsp_entry_distance;
            got.e_hits      = rsp_entry_hits;
            got.e_missed    = rsp_entry_missed;
            got.e_validated = rsp_entry_validated;
            got.removed     = rsp_removed_count;
            if (track_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request outstanding, status %0d",
                           $realtime, got.status);
            end else begin
               want = track_rsp_q.pop_front();
               if (got.status !== want.status || got.e_valid !== want.e_valid ||
                   got.e_id !== want.e_id || got.e_angle !== want.e_angle ||
                   got.e_distance !== want.e_distance || got.e_hits !== want.e_hits ||
                   got.e_missed !== want.e_missed ||
                   got.e_validated !== want.e_validated ||
                   got.removed !== want.removed) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: exp st %0d v %0d id %0d ang %0d dist %0d hits %0d",
                              $realtime, want.status, want.e_valid, want.e_id,
                              $signed(want.e_angle), want.e_distance, want.e_hits);
                     $display("   miss %0d vld %0d rm %0d", want.e_missed,
                              want.e_validated, want.removed);
                     $display("%0t: got st %0d v %0d id %0d ang %0d dist %0d hits %0d",
                              $realtime, got.status, got.e_valid, got.e_id,
                              $signed(got.e_angle), got.e_distance, got.e_hits);
                     $display("   miss %0d vld %0d rm %0d", got.e_missed,
                              got.e_validated, got.removed);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            track_rsp_q.insert(track_rsp_q.size(),
                               track_step(req_type, req_tag_id, req_tag_angle,
                                          req_tag_distance, req_read_index));
      end
      pending = track_rsp_q.size();
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the tag track table: clock, reset, request and register
// stimulus, response stalling, watchdog and verdict.
// Depends on ttt_pkg, tag_track_table and tag_track_checker.
`timescale 1ns / 1ps

module tb;

   import ttt_pkg::*;

   localparam int          SLOTS       = TABLE_SLOTS_DEF;
   localparam logic [1:0]  REQ_READ     = 2'd2;
   localparam logic [1:0]  REQ_READ_ALT = 2'd3;
   localparam int          PHASES      = 8;
   localparam int          PHASE_ITEMS = 166;
   localparam int          HOLD_CYCLES = 400;
   localparam int          IDLE_LIMIT  = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = REQ_DETECT;
   logic [TAG_ID_W-1:0]   req_tag_id = '0;
   logic signed [POSE_W-1:0] req_tag_angle = '0;
   logic [POSE_W-1:0]     req_tag_distance = '0;
   logic [READ_IDX_W-1:0] req_read_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_status;
   logic                  rsp_entry_valid;
   logic [TAG_ID_W-1:0]   rsp_entry_id;
   logic signed [POSE_W-1:0] rsp_entry_angle;
   logic [POSE_W-1:0]     rsp_entry_distance;
   logic [COUNT_W-1:0]    rsp_entry_hits;
   logic [COUNT_W-1:0]    rsp_entry_missed;
   logic                  rsp_entry_validated;
   logic [REMOVED_W-1:0]  rsp_removed_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = CSR_VALIDATION_HITS;
   logic [COUNT_W-1:0]    csr_data = '0;

   int fail_count;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   tag_track_table dut (.*);

   tag_track_checker #(.TABLE_SLOTS(SLOTS)) u_checker (.*);

   // Receiver: random stall, or one long counted hold-off when asked
   initial begin
      forever begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         @(posedge clock);
      end
   end

   // Watchdog: end the run when no handshake of any kind happens for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Offer one request after a random gap; return at the edge that takes it
   task automatic send_req(logic [1:0] kind, logic [TAG_ID_W-1:0] id,
         logic [POSE_W-1:0] ang, logic [POSE_W-1:0] rng, logic [READ_IDX_W-1:0] idx);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_type         <= kind;
      req_tag_id       <= id;
      req_tag_angle    <= ang;
      req_tag_distance <= rng;
      req_read_index   <= idx;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every response is back, then idle on before returning
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SLOTS + 4) @(posedge clock);
   endtask

   task automatic write_regs(logic [COUNT_W-1:0] vh, logic [COUNT_W-1:0] vf,
                             logic [COUNT_W-1:0] uf);
      logic [1:0]         regs [3];
      logic [COUNT_W-1:0] vals [3];
      regs[0] = CSR_VALIDATION_HITS;
      regs[1] = CSR_VALID_FORGET;
      regs[2] = CSR_UNVALID_FORGET;
      vals[0] = vh;
      vals[1] = vf;
      vals[2] = uf;
      for (int r = 0; r < 3; r++) begin
         csr_index <= regs[r];
         csr_data  <= vals[r];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      // 0 in a register column means pick a random legal value
      int ph_vh [PHASES] = '{1, 255, 3, 0, 2, 255, 0, 0};
      int ph_vf [PHASES] = '{1, 255, 6, 0, 255, 1, 0, 0};
      int ph_uf [PHASES] = '{1, 255, 2, 0, 1, 255, 0, 0};
      int vh, vf, uf;
      int pool_base, pool_size, pick, a, pause_at;
      logic [TAG_ID_W-1:0] id;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, pose extremes, repeats in a frame, saturation, forgetting
      send_req(REQ_READ, '0, '0, '0, 4'd0);
      send_req(REQ_READ_ALT, '1, '1, '1, 4'd15);
      send_req(REQ_DETECT, 10'd0, -16'sd18000, 16'd0, 4'd0);
      send_req(REQ_DETECT, 10'd1023, 16'sd18000, 16'd65535, 4'd15);
      send_req(REQ_DETECT, 10'd0, 16'sd1234, 16'd500, 4'd0);
      for (int k = 0; k < 6; k++)
         send_req(REQ_DETECT, 10'd7, 16'($urandom_range(0, 36000) - 18000),
                  16'($urandom_range(0, 65535)), 4'd0);
      for (int k = 0; k < 3; k++) send_req(REQ_READ, '0, '0, '0, 4'(k));
      for (int k = 0; k < 4; k++) send_req(REQ_AGE, '0, '0, '0, '0);
      for (int k = 0; k < 3; k++) send_req(REQ_READ, '0, '0, '0, 4'(k));
      send_req(REQ_AGE, '0, '0, '0, '0);
      send_req(REQ_READ_ALT, '0, '0, '0, 4'd2);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         vh = (ph_vh[ph] == 0) ? $urandom_range(1, 255) : ph_vh[ph];
         vf = (ph_vf[ph] == 0) ? $urandom_range(1, 255) : ph_vf[ph];
         uf = (ph_uf[ph] == 0) ? $urandom_range(1, 255) : ph_uf[ph];
         write_regs(8'(vh), 8'(vf), 8'(uf));
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         // fill the block while the receiver holds off
         if (ph == 2) hold_asked++;
         pause_at  = (ph == 4) ? PHASE_ITEMS / 2 : -1;
         pool_base = $urandom_range(0, 983);
         pool_size = $urandom_range(4, 40);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            a    = int'($urandom_range(0, 36000)) - 18000;
            if (pick < 62) begin
               if ($urandom_range(0, 9) == 0) id = 10'($urandom_range(0, 1023));
               else id = 10'(pool_base + $urandom_range(0, pool_size - 1));
               send_req(REQ_DETECT, id, a[POSE_W-1:0], 16'($urandom_range(0, 65535)),
                        4'($urandom));
            end else if (pick < 78) begin
               send_req(REQ_AGE, 10'($urandom), a[POSE_W-1:0], 16'($urandom),
                        4'($urandom));
            end else begin
               send_req(($urandom_range(0, 3) == 0) ? REQ_READ_ALT : REQ_READ,
                        10'($urandom), a[POSE_W-1:0], 16'($urandom),
                        4'($urandom_range(0, 15)));
            end
            if (n == pause_at) settle();
         end
      end

      settle();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ttt_pkg.sv
rtl/core/ttt_cell.sv
rtl/core/tag_track_table.sv
rtl/core/ttt_checker.sv
dv/tag_track_checker.sv
dv/tb.sv
